### design/mjmp_pkg.sv
package mjmp_pkg;

  localparam int JCB_DEF = 16;
  localparam int JCB_MAX = 32;

  localparam logic [31:0] MOD_FIRST  = 32'd4294967087;
  localparam logic [31:0] MOD_SECOND = 32'd4294944443;
  // 2^32 - modulus, used for folding the high half back in
  localparam logic [14:0] FOLD_FIRST  = 15'd209;
  localparam logic [14:0] FOLD_SECOND = 15'd22853;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_JUMP = 1'b1;
  localparam logic [2:0] WORD_LAST = 3'd5;

  typedef struct packed {
    logic               is_jump;
    logic [2:0]         idx;
    logic [31:0]        word;
    logic [JCB_MAX-1:0] count;
  } cmd_t;

  function automatic logic [31:0] jump_coef(input logic comp, input logic [1:0] r,
                                            input logic [1:0] c);
    logic [31:0] v;
    v = 32'd0;
    case ({comp, r, c})
      5'b0_00_00: v = 32'd2427906178;
      5'b0_00_01: v = 32'd3580155704;
      5'b0_00_10: v = 32'd949770784;
      5'b0_01_00: v = 32'd226153695;
      5'b0_01_01: v = 32'd1230515664;
      5'b0_01_10: v = 32'd3580155704;
      5'b0_10_00: v = 32'd1988835001;
      5'b0_10_01: v = 32'd986791581;
      5'b0_10_10: v = 32'd1230515664;
      5'b1_00_00: v = 32'd1464411153;
      5'b1_00_01: v = 32'd277697599;
      5'b1_00_10: v = 32'd1610723613;
      5'b1_01_00: v = 32'd32183930;
      5'b1_01_01: v = 32'd1464411153;
      5'b1_01_10: v = 32'd1022607788;
      5'b1_10_00: v = 32'd2824425944;
      5'b1_10_01: v = 32'd32183930;
      5'b1_10_10: v = 32'd2093834863;
      default:    v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

### design/mjmp_front.sv
module mjmp_front #(
  parameter int JUMP_COUNT_BITS = mjmp_pkg::JCB_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_func,
  input  logic [2:0]                 in_word_index,
  input  logic [31:0]                in_seed_word,
  input  logic [JUMP_COUNT_BITS-1:0] in_jump_count,
  output logic                       q_valid,
  input  logic                       q_pop,
  output mjmp_pkg::cmd_t             q_cmd
);
  import mjmp_pkg::*;

  cmd_t       ent_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       acc, push;
  cmd_t       cmd;

  assign in_stall = (cnt_r == 2'd2);
  assign acc      = in_valid && !in_stall;

  // loads to a word that does not exist are dropped here
  always_comb begin
    cmd.is_jump = (in_func == FUNC_JUMP);
    cmd.idx     = in_word_index;
    cmd.word    = in_seed_word;
    cmd.count   = JCB_MAX'(in_jump_count);
  end
  assign push = acc && (cmd.is_jump || in_word_index <= WORD_LAST);

  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd   = ent_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ q_pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= cmd;
  end

endmodule

### design/mjmp_back.sv
module mjmp_back #(
  parameter int JUMP_COUNT_BITS = mjmp_pkg::JCB_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  output logic           q_pop,
  input  mjmp_pkg::cmd_t q_cmd,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [2:0]     out_index,
  output logic [31:0]    out_state_word,
  output logic           out_last
);
  import mjmp_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_RED1 = 3'd2;
  localparam logic [2:0] S_RED2 = 3'd3;
  localparam logic [2:0] S_RED3 = 3'd4;
  localparam logic [2:0] S_ACC  = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  logic [2:0]                 st_r, st_nxt;
  logic [31:0]                word_r [6];
  logic [31:0]                nv_r [3];
  logic                       comp_r;
  logic [1:0]                 row_r, col_r;
  logic [2:0]                 k_r;
  logic [JUMP_COUNT_BITS-1:0] cnt_r;
  logic [63:0]                prod_r;
  logic [47:0]                y_r;
  logic [32:0]                z_r;
  logic [31:0]                zr_r, acc_r;
  logic                       ov_r;
  logic [2:0]                 oi_r;
  logic [31:0]                ow_r;
  logic                       ol_r;

  logic [2:0]  rd_idx;
  logic [31:0] rd_word, modv, acc_new;
  logic [14:0] fold;
  logic [32:0] sum;
  logic        out_free;

  assign modv   = comp_r ? MOD_SECOND : MOD_FIRST;
  assign fold   = comp_r ? FOLD_SECOND : FOLD_FIRST;
  assign rd_idx = (st_r == S_EMIT) ? k_r : ((comp_r ? 3'd3 : 3'd0) + {1'b0, col_r});
  assign rd_word = word_r[rd_idx];
  assign sum     = {1'b0, acc_r} + {1'b0, zr_r};
  assign acc_new = (sum >= {1'b0, modv}) ? 32'(sum - {1'b0, modv}) : sum[31:0];
  assign out_free = !ov_r || !out_stall;

  assign q_pop = (st_r == S_IDLE) && q_valid;

  assign out_valid      = ov_r;
  assign out_index      = oi_r;
  assign out_state_word = ow_r;
  assign out_last       = ol_r;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: begin
        if (q_valid && q_cmd.is_jump) begin
          st_nxt = (q_cmd.count[JUMP_COUNT_BITS-1:0] == '0) ? S_EMIT : S_MUL;
        end
      end
      S_MUL:  st_nxt = S_RED1;
      S_RED1: st_nxt = S_RED2;
      S_RED2: st_nxt = S_RED3;
      S_RED3: st_nxt = S_ACC;
      S_ACC: begin
        if (col_r == 2'd2 && row_r == 2'd2 && comp_r && cnt_r == JUMP_COUNT_BITS'(1)) begin
          st_nxt = S_EMIT;
        end else begin
          st_nxt = S_MUL;
        end
      end
      S_EMIT: if (out_free && k_r == WORD_LAST) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      ov_r   <= 1'b0;
      comp_r <= 1'b0;
      row_r  <= 2'd0;
      col_r  <= 2'd0;
      k_r    <= 3'd0;
      acc_r  <= 32'd0;
      for (int i = 0; i < 6; i++) word_r[i] <= 32'd0;
    end else begin
      st_r <= st_nxt;
      if (st_r == S_EMIT && out_free) ov_r <= 1'b1;
      else if (ov_r && !out_stall) ov_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (q_valid) begin
            if (q_cmd.is_jump) begin
              cnt_r  <= q_cmd.count[JUMP_COUNT_BITS-1:0];
              comp_r <= 1'b0;
              row_r  <= 2'd0;
              col_r  <= 2'd0;
              k_r    <= 3'd0;
              acc_r  <= 32'd0;
            end else begin
              word_r[q_cmd.idx] <= q_cmd.word;
            end
          end
        end
        S_MUL:  prod_r <= 64'(jump_coef(comp_r, row_r, col_r)) * 64'(rd_word);
        S_RED1: y_r <= 48'(prod_r[63:32]) * 48'(fold) + 48'(prod_r[31:0]);
        S_RED2: z_r <= 33'(y_r[47:32]) * 33'(fold) + 33'(y_r[31:0]);
        S_RED3: zr_r <= (z_r >= {1'b0, modv}) ? 32'(z_r - {1'b0, modv}) : z_r[31:0];
        S_ACC: begin
          if (col_r != 2'd2) begin
            acc_r <= acc_new;
            col_r <= col_r + 2'd1;
          end else begin
            acc_r <= 32'd0;
            col_r <= 2'd0;
            nv_r[row_r] <= acc_new;
            if (row_r != 2'd2) begin
              row_r <= row_r + 2'd1;
            end else begin
              row_r <= 2'd0;
              // component finished: commit its three new words
              word_r[comp_r ? 3'd3 : 3'd0] <= nv_r[0];
              word_r[comp_r ? 3'd4 : 3'd1] <= nv_r[1];
              word_r[comp_r ? 3'd5 : 3'd2] <= acc_new;
              comp_r <= !comp_r;
              if (comp_r) cnt_r <= cnt_r - JUMP_COUNT_BITS'(1);
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            oi_r <= k_r;
            ow_r <= rd_word;
            ol_r <= (k_r == WORD_LAST);
            k_r  <= k_r + 3'd1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

### design/mrg32k3a_stream_jump_unit.sv
// Channel | Ports                                              | Direction
// input   | in_valid/in_stall, in_func, in_word_index,         | in
//         | in_seed_word, in_jump_count                        |
// result  | out_valid/out_stall, out_index, out_state_word,    | out
//         | out_last                                           |
//
// Operation: a load is written into its state word in the back end. A jump
//   is taken from the queue, then runs 18 multiply-accumulates per advance,
//   each through the MUL, RED1, RED2, RED3 and ACC states on the single
//   shared mod-multiply unit, and then emits the six state words.
// Reset: rst_n, synchronous, active low; clears the six state words.
// Stalls: a two-entry queue parts the front from the back, so inputs keep
//   transferring while a jump runs until both entries are taken; the result
//   register holds under out_stall.
module mrg32k3a_stream_jump_unit #(
  parameter int JUMP_COUNT_BITS = mjmp_pkg::JCB_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_func,
  input  logic [2:0]                 in_word_index,
  input  logic [31:0]                in_seed_word,
  input  logic [JUMP_COUNT_BITS-1:0] in_jump_count,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [2:0]                 out_index,
  output logic [31:0]                out_state_word,
  output logic                       out_last
);
  import mjmp_pkg::*;

  logic q_valid, q_pop;
  cmd_t q_cmd;

  // front: decode and queue
  mjmp_front #(.JUMP_COUNT_BITS(JUMP_COUNT_BITS)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_func, .in_word_index,
    .in_seed_word, .in_jump_count, .q_valid, .q_pop, .q_cmd
  );

  // back: state words, modular matrix engine, result register
  mjmp_back #(.JUMP_COUNT_BITS(JUMP_COUNT_BITS)) u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_cmd, .out_valid, .out_stall,
    .out_index, .out_state_word, .out_last
  );

endmodule
